@@ hdl/cbt_pkg.sv @@
package cbt_pkg;

  // Field widths
  localparam int RATE_W    = 20;
  localparam int CLOCK_W   = 28;
  localparam int PRESC_W   = 9;
  localparam int QUANTA_W  = 6;
  localparam int SEG1_W    = 6;
  localparam int SEG2_W    = 5;
  localparam int SJW_W     = 3;
  localparam int TWORD_W   = 26;
  localparam int FRAME_W   = 28;

  // Search limits and timing rules
  localparam int MAX_PRESCALER_DEF = 256;
  localparam int MIN_QUANTA        = 8;
  localparam int MAX_QUANTA        = 49;
  localparam int MAX_TSEG1         = 32;
  localparam int MIN_TSEG2         = 2;
  localparam int MAX_SJW           = 4;
  localparam logic [CLOCK_W-1:0] FRAME_BITS_US = CLOCK_W'(160000000);
  localparam logic [CLOCK_W-1:0] CLOCK_RESET   = CLOCK_W'(27000000);

  // x / 10 for x below 1029 as (x * 205) >> 11
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SHIFT = 11;

  // Shift-subtract divider: one quotient bit per cycle
  localparam int DIV_STEPS = CLOCK_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [RATE_W-1:0] bit_rate;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic [PRESC_W-1:0]  prescaler;
    logic [QUANTA_W-1:0] quanta_per_bit;
    logic [SEG1_W-1:0]   phase_seg1;
    logic [SEG2_W-1:0]   phase_seg2;
    logic [SJW_W-1:0]    sync_jump;
    logic [TWORD_W-1:0]  timing_word;
    logic [FRAME_W-1:0]  frame_time_us;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic start_trial;
    logic div_step;
    logic next_presc;
    logic capture;
    logic start_frame;
    logic write_ok;
    logic write_fail;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rate_zero;
    logic d_over;
    logic exact;
    logic n_low;
    logic n_fit;
    logic last_presc;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/cbt_if.sv @@
interface cbt_req_if;
  logic          valid;
  logic          ready;
  cbt_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cbt_rsp_if;
  logic          valid;
  logic          ready;
  cbt_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cbt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cbt_pkg::CLOCK_W-1:0]  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hdl/cbt_ctrl.sv @@
module cbt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cbt_pkg::sts_t sts,
  output cbt_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TRIAL = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_FRAME = 3'd4;
  localparam logic [2:0] S_FDIV  = 3'd5;
  localparam logic [2:0] S_WOK   = 3'd6;
  localparam logic [2:0] S_WFAIL = 3'd7;

  localparam logic [cbt_pkg::STEP_W-1:0] LAST_STEP =
    cbt_pkg::STEP_W'(cbt_pkg::DIV_STEPS - 1);

  logic [2:0]                 state, state_next;
  logic [cbt_pkg::STEP_W-1:0] step, step_next;

  assign req_ready = (state == S_IDLE);

  // Sequence the prescaler search, the frame division and the result write
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_TRIAL;
        end
      end
      S_TRIAL: begin
        if (sts.rate_zero || sts.d_over) begin
          state_next = S_WFAIL;
        end else begin
          cmd.start_trial = 1'b1;
          step_next       = '0;
          state_next      = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == LAST_STEP) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.exact && sts.n_low) begin
          state_next = S_WFAIL;
        end else if (sts.exact && sts.n_fit) begin
          cmd.capture = 1'b1;
          state_next  = S_FRAME;
        end else if (sts.last_presc) begin
          state_next = S_WFAIL;
        end else begin
          cmd.next_presc = 1'b1;
          state_next     = S_TRIAL;
        end
      end
      S_FRAME: begin
        cmd.start_frame = 1'b1;
        step_next       = '0;
        state_next      = S_FDIV;
      end
      S_FDIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == LAST_STEP) state_next = S_WOK;
      end
      S_WOK: begin
        if (sts.out_free) begin
          cmd.write_ok = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_WFAIL: begin
        if (sts.out_free) begin
          cmd.write_fail = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

@@ hdl/cbt_datapath.sv @@
module cbt_datapath #(
  parameter int MAX_PRESCALER = cbt_pkg::MAX_PRESCALER_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cbt_pkg::RATE_W-1:0]  bit_rate,
  input  cbt_pkg::cmd_t               cmd,
  output cbt_pkg::sts_t               sts,
  cbt_cfg_if.sink                     cfg,
  cbt_rsp_if.source                   rsp
);

  localparam int PW = $clog2(MAX_PRESCALER + 1);
  localparam int DW = cbt_pkg::RATE_W + PW;
  localparam int QW = cbt_pkg::CLOCK_W;

  logic [cbt_pkg::CLOCK_W-1:0]  clock_hz;
  logic [cbt_pkg::RATE_W-1:0]   rate;
  logic [PW-1:0]                presc;
  logic [PW-1:0]                brp;
  logic [DW-1:0]                divisor;
  logic [DW-1:0]                rem;
  logic [QW-1:0]                quo;
  logic [cbt_pkg::QUANTA_W-1:0] tq;
  logic                         rsp_valid;
  cbt_pkg::rsp_t                rsp_data;

  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_step;

  // One restoring divide step
  always_comb begin
    trial    = {rem, quo[QW-1]};
    ge       = (trial >= {1'b0, divisor});
    rem_step = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
  end

  assign sts.rate_zero  = (rate == '0);
  assign sts.d_over     = (divisor > DW'(clock_hz));
  assign sts.exact      = (rem == '0);
  assign sts.n_low      = (quo < QW'(cbt_pkg::MIN_QUANTA));
  assign sts.n_fit      = (quo <= QW'(cbt_pkg::MAX_QUANTA));
  assign sts.last_presc = (presc == PW'(MAX_PRESCALER));
  assign sts.out_free   = !rsp_valid || rsp.ready;

  // Place TSEG2 near 20 percent, cap TSEG1, derive SJW
  logic [6:0]                 seg_x;
  logic [14:0]                seg_prod;
  logic [cbt_pkg::SEG1_W-1:0] seg2_raw;
  logic [cbt_pkg::SEG1_W-1:0] seg2_min;
  logic [cbt_pkg::SEG1_W-1:0] seg1_raw;
  logic [cbt_pkg::SEG1_W-1:0] seg1;
  logic [cbt_pkg::SEG1_W-1:0] seg2;
  logic [cbt_pkg::SEG1_W-1:0] sjw;
  logic [PW-1:0]              brp_m1;
  cbt_pkg::rsp_t              rsp_ok;

  always_comb begin
    seg_x    = {tq, 1'b0} + 7'd5;
    seg_prod = 15'(seg_x) * 15'(cbt_pkg::DIV10_MUL);
    seg2_raw = cbt_pkg::SEG1_W'(seg_prod >> cbt_pkg::DIV10_SHIFT);
    seg2_min = (seg2_raw < cbt_pkg::SEG1_W'(cbt_pkg::MIN_TSEG2)) ?
               cbt_pkg::SEG1_W'(cbt_pkg::MIN_TSEG2) : seg2_raw;
    seg1_raw = tq - 1'b1 - seg2_min;
    if (seg1_raw > cbt_pkg::SEG1_W'(cbt_pkg::MAX_TSEG1)) begin
      seg1 = cbt_pkg::SEG1_W'(cbt_pkg::MAX_TSEG1);
      seg2 = tq - 1'b1 - cbt_pkg::SEG1_W'(cbt_pkg::MAX_TSEG1);
    end else begin
      seg1 = seg1_raw;
      seg2 = seg2_min;
    end
    sjw    = (seg2 < cbt_pkg::SEG1_W'(cbt_pkg::MAX_SJW)) ?
             seg2 : cbt_pkg::SEG1_W'(cbt_pkg::MAX_SJW);
    brp_m1 = brp - 1'b1;

    rsp_ok.ok             = 1'b1;
    rsp_ok.prescaler      = cbt_pkg::PRESC_W'(brp);
    rsp_ok.quanta_per_bit = tq;
    rsp_ok.phase_seg1     = seg1;
    rsp_ok.phase_seg2     = cbt_pkg::SEG2_W'(seg2);
    rsp_ok.sync_jump      = cbt_pkg::SJW_W'(sjw);
    rsp_ok.timing_word    = {2'(sjw - 1'b1), 8'(seg2 - 1'b1),
                             8'(seg1 - 1'b1), 8'(brp_m1)};
    rsp_ok.frame_time_us  = cbt_pkg::FRAME_W'(quo);
  end

  // Hold the configured clock
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= cbt_pkg::CLOCK_RESET;
    end else if (cfg.valid) begin
      clock_hz <= cfg.data;
    end
  end

  // Search and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rate    <= bit_rate;
      presc   <= PW'(1);
      divisor <= DW'(bit_rate);
    end
    if (cmd.next_presc) begin
      presc   <= presc + 1'b1;
      divisor <= divisor + DW'(rate);
    end
    if (cmd.start_trial) begin
      rem <= '0;
      quo <= clock_hz;
    end
    if (cmd.start_frame) begin
      rem     <= '0;
      quo     <= cbt_pkg::FRAME_BITS_US;
      divisor <= DW'(rate);
    end
    if (cmd.div_step) begin
      rem <= rem_step;
      quo <= {quo[QW-2:0], ge};
    end
    if (cmd.capture) begin
      tq  <= quo[cbt_pkg::QUANTA_W-1:0];
      brp <= presc;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.write_ok) rsp_data <= rsp_ok;
    else if (cmd.write_fail) rsp_data <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.write_ok || cmd.write_fail) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

endmodule

@@ hdl/can_bit_timing_calculator.sv @@
// CAN bit timing calculator.
// req carries one requested bit rate per word; rsp returns one timing word
// per request: ok, prescaler, quanta per bit, TSEG1, TSEG2, SJW, the packed
// timing word and the 160-bit frame time in microseconds (all zero on fail).
// cfg writes the controller clock frequency in hertz and is always ready;
// the user must write it only while no request is in flight; not enforced.
// Operation: a request is loaded, then each prescaler tried takes one
// 28-step shift-subtract division and a check, then a frame-time division
// runs and the result is written. The search ends early once rate *
// prescaler exceeds the clock or an exact division gives at most 49 quanta
// per bit. One request is worked at a time; the divider is shared by the
// prescaler search and the frame-time division.
// Reset clears the controller, empties the output register and sets the
// clock to 27 MHz. A stalled receiver holds the result in the output
// register; a new request may be accepted meanwhile and waits before its
// write until the held word is taken.
module can_bit_timing_calculator #(
  parameter int MAX_PRESCALER = cbt_pkg::MAX_PRESCALER_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cbt_req_if.sink    req,
  cbt_rsp_if.source  rsp,
  cbt_cfg_if.sink    cfg
);

  cbt_pkg::cmd_t cmd;
  cbt_pkg::sts_t sts;

  cbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbt_datapath #(
    .MAX_PRESCALER (MAX_PRESCALER)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .bit_rate (req.data.bit_rate),
    .cmd      (cmd),
    .sts      (sts),
    .cfg      (cfg),
    .rsp      (rsp)
  );

endmodule

@@ hdl/cbt_checker.sv @@
module cbt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input cbt_pkg::rsp_t rsp_data
);

  // Output register empties on reset
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");

  // One request in flight
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");

  // Failure clears every field
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.ok |-> rsp_data == '0)
    else $error("failed result has nonzero fields");

  // Segments add up to the bit
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.ok |->
      rsp_data.quanta_per_bit >= 6'(cbt_pkg::MIN_QUANTA) &&
      rsp_data.quanta_per_bit <= 6'(cbt_pkg::MAX_QUANTA) &&
      7'(rsp_data.phase_seg1) + 7'(rsp_data.phase_seg2) + 7'd1 ==
        7'(rsp_data.quanta_per_bit) &&
      5'(rsp_data.sync_jump) <= rsp_data.phase_seg2)
    else $error("inconsistent timing result");

endmodule

bind can_bit_timing_calculator cbt_checker u_cbt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
